// File: hdl/pcsm_pkg.sv
// ----------------------------------------------------------------------------
// pcsm_pkg: shared types and codes of the pedal change state machine
// Foot, operation and outcome codes, register indexes, beat layouts.
// ----------------------------------------------------------------------------
package pcsm_pkg;

	// Default width of the elapsed and needed time registers
	localparam int TIME_BITS_DEFAULT = 16;

	// Stream and configuration port widths
	localparam int S_TDATA_W  = 56;
	localparam int S_TUSER_W  = 1;
	localparam int M_TDATA_W  = 24;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_STEP_TIME        = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_RESISTANCE_ACCEL = 1'd1;

	// Register reset values
	localparam logic [9:0]         STEP_TIME_RESET        = 10'd100;
	localparam logic signed [15:0] RESISTANCE_ACCEL_RESET = 16'sd200;

	// Foot positions
	localparam logic [1:0] FOOT_ACCEL = 2'd0;
	localparam logic [1:0] FOOT_BRAKE = 2'd1;
	localparam logic [1:0] FOOT_FREE  = 2'd2;

	// Operations
	localparam logic OP_UPDATE  = 1'b0;
	localparam logic OP_EXECUTE = 1'b1;

	// Change outcomes
	localparam logic [1:0] RES_NO_CHANGE = 2'd0;
	localparam logic [1:0] RES_CHANGING  = 2'd1;
	localparam logic [1:0] RES_CHANGED   = 2'd2;
	localparam logic [1:0] RES_IMMEDIATE = 2'd3;

	// Configuration registers as seen by the state machine
	typedef struct packed {
		logic [9:0]         step_time;
		logic signed [15:0] resistance_accel;
	} cfg_t;

	// One input item
	typedef struct packed {
		logic               operation;
		logic signed [15:0] next_accel;
		logic [15:0]        accel_to_brake_time;
		logic [15:0]        brake_to_accel_time;
		logic               recognition_hit;
	} item_t;

	// One result item
	typedef struct packed {
		logic [1:0]  change_result;
		logic [1:0]  foot_now;
		logic [1:0]  foot_target;
		logic        is_changing;
		logic [15:0] needed_time;
	} result_t;

endpackage

// File: hdl/pcsm_fsm.sv
// ----------------------------------------------------------------------------
// pcsm_fsm: pedal state and next-state logic
// Holds foot, target, change flag, elapsed and needed time; works out the
// next state and the result of one item combinationally.
// ----------------------------------------------------------------------------
module pcsm_fsm #(
	parameter int TIME_BITS = pcsm_pkg::TIME_BITS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pcsm_pkg::cfg_t    cfg,
	input  pcsm_pkg::item_t   item,
	input  logic              advance,
	output pcsm_pkg::result_t result
);

	localparam int CW = (TIME_BITS > 16) ? TIME_BITS : 16;
	localparam int SW = ((TIME_BITS > 10) ? TIME_BITS : 10) + 1;

	logic [1:0]           foot_q;
	logic [1:0]           target_q;
	logic                 changing_q;
	logic [TIME_BITS-1:0] elapsed_q;
	logic [TIME_BITS-1:0] need_q;

	logic [1:0]           foot_d;
	logic [1:0]           target_d;
	logic                 changing_d;
	logic [TIME_BITS-1:0] elapsed_d;
	logic [TIME_BITS-1:0] need_d;
	logic [1:0]           outcome;

	logic [SW-1:0]        sum_w;
	logic [TIME_BITS-1:0] elapsed_inc;
	logic signed [16:0]   thr;
	logic signed [16:0]   acc_w;
	logic                 acc_gt;
	logic                 acc_lt;
	logic [CW-1:0]        el_w;
	logic [CW-1:0]        a2b_w;
	logic [CW-1:0]        b2a_w;
	logic [CW-1:0]        min_a2b;
	logic [CW-1:0]        min_b2a;
	logic [CW-1:0]        half_a2b;
	logic [CW-1:0]        half_b2a;
	logic [CW-1:0]        need_w;

	// Saturating advance of the elapsed time while a change runs
	assign sum_w       = SW'(elapsed_q) + SW'(cfg.step_time);
	assign elapsed_inc = (|sum_w[SW-1:TIME_BITS]) ? '1 : sum_w[TIME_BITS-1:0];

	// Compare the wanted acceleration with the negated resistance
	assign thr    = -signed'({cfg.resistance_accel[15], cfg.resistance_accel});
	assign acc_w  = signed'({item.next_accel[15], item.next_accel});
	assign acc_gt = acc_w > thr;
	assign acc_lt = acc_w < thr;

	// Candidate needed times at a common width
	assign el_w     = CW'(changing_q ? elapsed_inc : elapsed_q);
	assign a2b_w    = CW'(item.accel_to_brake_time);
	assign b2a_w    = CW'(item.brake_to_accel_time);
	assign min_a2b  = (el_w < a2b_w) ? el_w : a2b_w;
	assign min_b2a  = (el_w < b2a_w) ? el_w : b2a_w;
	assign half_a2b = a2b_w >> 1;
	assign half_b2a = b2a_w >> 1;

	// Next state and outcome of one item
	always_comb begin
		foot_d     = foot_q;
		target_d   = target_q;
		changing_d = changing_q;
		elapsed_d  = elapsed_q;
		need_d     = need_q;
		outcome    = pcsm_pkg::RES_NO_CHANGE;
		if (item.operation == pcsm_pkg::OP_UPDATE) begin
			if (changing_q) begin
				elapsed_d = elapsed_inc;
			end
			unique case (foot_q)
				pcsm_pkg::FOOT_ACCEL: begin
					if (acc_gt) begin
						changing_d = 1'b0;
						elapsed_d  = '0;
						target_d   = pcsm_pkg::FOOT_ACCEL;
					end else begin
						changing_d = 1'b1;
						if (acc_lt) begin
							need_d   = a2b_w[TIME_BITS-1:0];
							target_d = pcsm_pkg::FOOT_BRAKE;
						end else begin
							need_d   = '0;
							target_d = pcsm_pkg::FOOT_FREE;
						end
					end
				end
				pcsm_pkg::FOOT_BRAKE: begin
					if (acc_lt) begin
						changing_d = 1'b0;
						elapsed_d  = '0;
						target_d   = pcsm_pkg::FOOT_BRAKE;
					end else begin
						changing_d = 1'b1;
						if (acc_gt) begin
							need_d   = b2a_w[TIME_BITS-1:0];
							target_d = pcsm_pkg::FOOT_ACCEL;
						end else begin
							need_d   = '0;
							target_d = pcsm_pkg::FOOT_FREE;
						end
					end
				end
				pcsm_pkg::FOOT_FREE: begin
					if (acc_gt) begin
						// Turn back from brake or start from rest toward accelerator
						if (target_q != pcsm_pkg::FOOT_ACCEL) begin
							if (target_q == pcsm_pkg::FOOT_BRAKE) begin
								need_d = min_b2a[TIME_BITS-1:0];
							end else if (target_q == pcsm_pkg::FOOT_FREE) begin
								need_d = half_b2a[TIME_BITS-1:0];
							end
							changing_d = 1'b1;
							elapsed_d  = '0;
							target_d   = pcsm_pkg::FOOT_ACCEL;
						end
					end else if (acc_lt) begin
						if (target_q != pcsm_pkg::FOOT_BRAKE) begin
							if (target_q == pcsm_pkg::FOOT_ACCEL) begin
								need_d = min_a2b[TIME_BITS-1:0];
							end else if (target_q == pcsm_pkg::FOOT_FREE) begin
								need_d = half_a2b[TIME_BITS-1:0];
							end
							changing_d = 1'b1;
							elapsed_d  = '0;
							target_d   = pcsm_pkg::FOOT_BRAKE;
						end
					end else begin
						changing_d = 1'b0;
						elapsed_d  = '0;
						target_d   = pcsm_pkg::FOOT_FREE;
					end
				end
				default: begin
					// Unused foot code: only the elapsed advance applies
				end
			endcase
		end else begin
			if (changing_q) begin
				if (elapsed_q >= need_q) begin
					changing_d = 1'b0;
					elapsed_d  = '0;
					foot_d     = target_q;
					outcome    = pcsm_pkg::RES_CHANGED;
				end else begin
					foot_d  = pcsm_pkg::FOOT_FREE;
					outcome = pcsm_pkg::RES_CHANGING;
				end
			end else if (item.recognition_hit) begin
				elapsed_d = '0;
				foot_d    = target_q;
				outcome   = pcsm_pkg::RES_IMMEDIATE;
			end
		end
	end

	// Result fields follow the state after the item
	assign need_w               = CW'(need_d);
	assign result.change_result = outcome;
	assign result.foot_now      = foot_d;
	assign result.foot_target   = target_d;
	assign result.is_changing   = changing_d;
	assign result.needed_time   = need_w[15:0];

	// Commit the state when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foot_q     <= pcsm_pkg::FOOT_FREE;
			target_q   <= pcsm_pkg::FOOT_FREE;
			changing_q <= 1'b0;
			elapsed_q  <= '0;
			need_q     <= '0;
		end else if (advance) begin
			foot_q     <= foot_d;
			target_q   <= target_d;
			changing_q <= changing_d;
			elapsed_q  <= elapsed_d;
			need_q     <= need_d;
		end
	end

	// Elapsed time only runs during a change
	a_idle_elapsed_zero: assert property (
		@(posedge clk) disable iff (!arst_n)
		!changing_q |-> elapsed_q == '0
	) else $error("elapsed time nonzero with no change in progress");

	// Elapsed time grows, saturates or clears, never steps back otherwise
	a_elapsed_monotonic: assert property (
		@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (elapsed_q >= $past(elapsed_q)) || (elapsed_q == '0)
	) else $error("elapsed time went backward");

	// An execute during a change either completes it or leaves the foot free
	a_execute_changing: assert property (
		@(posedge clk) disable iff (!arst_n)
		advance && item.operation == pcsm_pkg::OP_EXECUTE && changing_q
			|=> !changing_q || foot_q == pcsm_pkg::FOOT_FREE
	) else $error("execute during change left foot on a pedal");

endmodule

// File: hdl/pedal_change_state_machine_top.sv
// ----------------------------------------------------------------------------
// pedal_change_state_machine_top: driver pedal change state machine
// Stream wrapper with input register, configuration registers and result
// register around the pedal state logic.
// ----------------------------------------------------------------------------
// Takes one beat per clock cycle while the result stream is not stalled and
// returns one result beat per input beat, in order; each beat passes through
// the input register, then the result register. The rate is set by the
// combinational next-state step of the pedal state, which each beat reads and
// updates. A held result does not stop the next input beat from being taken
// into an empty input register. Write step_time and resistance_accel only
// while no beat is in flight; there is no clearing pass after reset.
module pedal_change_state_machine_top #(
	parameter int TIME_BITS = pcsm_pkg::TIME_BITS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// next_accel[15:0], accel_to_brake_time[31:16], brake_to_accel_time[47:32],
	// recognition_hit[48], zero fill [55:49]
	input  logic [pcsm_pkg::S_TDATA_W-1:0]   s_tdata,
	// operation[0]
	input  logic [pcsm_pkg::S_TUSER_W-1:0]   s_tuser,
	// Result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// change_result[1:0], foot_now[3:2], foot_target[5:4], is_changing[6],
	// needed_time[22:7], zero fill [23]
	output logic [pcsm_pkg::M_TDATA_W-1:0]   m_tdata,
	// Configuration writes
	input  logic                             cfg_we,
	input  logic [pcsm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [pcsm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	pcsm_pkg::cfg_t    cfg_q;
	pcsm_pkg::item_t   item_in;
	pcsm_pkg::item_t   item_s1;
	logic              valid_s1;
	pcsm_pkg::result_t result_d;
	pcsm_pkg::result_t result_s2;
	logic              valid_s2;
	logic              advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_time        <= pcsm_pkg::STEP_TIME_RESET;
			cfg_q.resistance_accel <= pcsm_pkg::RESISTANCE_ACCEL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				pcsm_pkg::REG_STEP_TIME:        cfg_q.step_time <= cfg_data[9:0];
				pcsm_pkg::REG_RESISTANCE_ACCEL: cfg_q.resistance_accel <= signed'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// Unpack the input beat
	assign item_in.operation           = s_tuser[0];
	assign item_in.next_accel          = signed'(s_tdata[15:0]);
	assign item_in.accel_to_brake_time = s_tdata[31:16];
	assign item_in.brake_to_accel_time = s_tdata[47:32];
	assign item_in.recognition_hit     = s_tdata[48];

	// Move the held item on when the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

	pcsm_fsm #(
		.TIME_BITS (TIME_BITS)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.item    (item_s1),
		.advance (advance),
		.result  (result_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	// Pack the result beat
	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, result_s2.needed_time, result_s2.is_changing,
		result_s2.foot_target, result_s2.foot_now, result_s2.change_result};

	// A held item that cannot move on stays put
	a_hold_s1: assert property (
		@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1)
	) else $error("input register lost a held beat");

	// Every item that moves on shows up as a result beat
	a_advance_result: assert property (
		@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2
	) else $error("advanced beat produced no result");

	// A result beat that is not taken holds steady
	a_hold_s2: assert property (
		@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
	) else $error("result beat changed while stalled");

endmodule
